// ----- rtl/infix_to_postfix_converter_macros.svh -----
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ITP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define ITP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/itp_pkg.sv -----
package itp_pkg;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MEM_DEPTH   = STACK_DEPTH - 1;
  localparam int unsigned MEM_AW      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam logic [3:0] OP_EQ  = 4'd0;
  localparam logic [3:0] OP_NE  = 4'd1;
  localparam logic [3:0] OP_LT  = 4'd2;
  localparam logic [3:0] OP_LE  = 4'd3;
  localparam logic [3:0] OP_GT  = 4'd4;
  localparam logic [3:0] OP_GE  = 4'd5;
  localparam logic [3:0] OP_OR  = 4'd6;
  localparam logic [3:0] OP_AND = 4'd7;
  localparam logic [3:0] OP_ADD = 4'd8;
  localparam logic [3:0] OP_SUB = 4'd9;
  localparam logic [3:0] OP_MUL = 4'd10;
  localparam logic [3:0] OP_DIV = 4'd11;
  localparam logic [3:0] OP_NOT = 4'd12;

  typedef enum logic [2:0] {
    OPC_OPERAND  = 3'd0,
    OPC_LPAREN   = 3'd1,
    OPC_RPAREN   = 3'd2,
    OPC_OPERATOR = 3'd3,
    OPC_END      = 3'd4
  } itp_opcode_e;

  typedef enum logic [1:0] {
    KIND_OPERAND  = 2'd0,
    KIND_OPERATOR = 2'd1,
    KIND_END      = 2'd2,
    KIND_ERROR    = 2'd3
  } itp_kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } itp_state_e;

  typedef struct packed {
    logic        lp;
    logic [3:0]  op;
    logic [15:0] tag;
  } itp_entry_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       op_ok;
    logic       empty;
    logic       full;
    logic       top_lp;
    logic       top_yields;
    logic       nxt_lp;
    logic       nxt_yields;
    logic       out_free;
  } itp_stat_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    itp_kind_e kind;
    logic      from_top;
    logic      last;
    logic      pop;
    logic      push;
    logic      clear;
  } itp_cmd_t;

  function automatic logic [2:0] itp_prec(input logic [3:0] op);
    logic [2:0] p;
    p = 3'd0;
    case (op)
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE: p = 3'd1;
      OP_OR:                                    p = 3'd2;
      OP_AND:                                   p = 3'd3;
      OP_ADD, OP_SUB:                           p = 3'd4;
      OP_MUL, OP_DIV:                           p = 3'd5;
      OP_NOT:                                   p = 3'd6;
      default:                                  p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/infix_to_postfix_converter.sv -----
// Channel   Dir  tuser           tdata                              tlast
// s_axis    in   opcode [2:0]    operator_code [3:0], token_tag     -
// m_axis    out  out_kind [1:0]  out_operator_code [3:0], out_tag   last
//
// Each word is accepted in ST_IDLE, then run in ST_RUN one stack step at a time: an
// operand or a push is a single step, a word that pops k entries takes at most k + 1 steps.
// One stack step per cycle: the top-of-stack register and one stack read/write.
// Reset empties the stack; stack contents need no clearing.
// A stalled m_axis holds the engine; a new word is taken while a result waits.

module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // operator_code [3:0], token_tag [19:4], zero pad
  input  logic [2:0]  s_axis_tuser_i,  // opcode [2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // out_operator_code [3:0], out_token_tag [19:4], pad
  output logic [1:0]  m_axis_tuser_o,  // out_kind [1:0]
  output logic        m_axis_tlast_o
);

  itp_cmd_t    cmd;
  itp_stat_t   stat;
  itp_kind_e   out_kind;
  logic [3:0]  out_op;
  logic [15:0] out_tag;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  itp_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_opcode_i         (s_axis_tuser_i),
    .in_operator_code_i  (s_axis_tdata_i[3:0]),
    .in_token_tag_i      (s_axis_tdata_i[19:4]),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .out_valid_o         (m_axis_tvalid_o),
    .out_ready_i         (m_axis_tready_i),
    .out_kind_o          (out_kind),
    .out_operator_code_o (out_op),
    .out_token_tag_o     (out_tag),
    .out_last_o          (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, out_tag, out_op};
  assign m_axis_tuser_o = out_kind;

endmodule

// ----- rtl/itp_ctrl.sv -----
`include "infix_to_postfix_converter_macros.svh"

module itp_ctrl
  import itp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  itp_stat_t stat_i,
  output itp_cmd_t  cmd_o
);

  itp_state_e state_q, state_d;
  logic       done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = KIND_OPERAND;
    done       = 1'b0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      ST_RUN: begin
        unique case (stat_i.opcode)
          OPC_OPERAND: begin
            if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = KIND_OPERAND;
              cmd_o.last = 1'b1;
              done       = 1'b1;
            end
          end
          OPC_LPAREN: begin
            if (!stat_i.full) begin
              cmd_o.push = 1'b1;
              done       = 1'b1;
            end else if (stat_i.out_free) begin
              cmd_o.emit  = 1'b1;
              cmd_o.kind  = KIND_ERROR;
              cmd_o.last  = 1'b1;
              cmd_o.clear = 1'b1;
              done        = 1'b1;
            end
          end
          OPC_RPAREN: begin
            if (stat_i.empty) begin
              if (stat_i.out_free) begin
                cmd_o.emit  = 1'b1;
                cmd_o.kind  = KIND_ERROR;
                cmd_o.last  = 1'b1;
                cmd_o.clear = 1'b1;
                done        = 1'b1;
              end
            end else if (stat_i.top_lp) begin
              cmd_o.pop = 1'b1;
              done      = 1'b1;
            end else if (stat_i.out_free) begin
              cmd_o.emit     = 1'b1;
              cmd_o.kind     = KIND_OPERATOR;
              cmd_o.from_top = 1'b1;
              cmd_o.last     = stat_i.nxt_lp;
              cmd_o.pop      = 1'b1;
            end
          end
          OPC_OPERATOR: begin
            if (!stat_i.op_ok) begin
              if (stat_i.out_free) begin
                cmd_o.emit  = 1'b1;
                cmd_o.kind  = KIND_ERROR;
                cmd_o.last  = 1'b1;
                cmd_o.clear = 1'b1;
                done        = 1'b1;
              end
            end else if (!stat_i.empty && stat_i.top_yields) begin
              if (stat_i.out_free) begin
                cmd_o.emit     = 1'b1;
                cmd_o.kind     = KIND_OPERATOR;
                cmd_o.from_top = 1'b1;
                cmd_o.last     = !stat_i.nxt_yields;
                cmd_o.pop      = 1'b1;
              end
            end else if (!stat_i.full) begin
              cmd_o.push = 1'b1;
              done       = 1'b1;
            end else if (stat_i.out_free) begin
              cmd_o.emit  = 1'b1;
              cmd_o.kind  = KIND_ERROR;
              cmd_o.last  = 1'b1;
              cmd_o.clear = 1'b1;
              done        = 1'b1;
            end
          end
          OPC_END: begin
            if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              if (stat_i.empty) begin
                cmd_o.kind = KIND_END;
                cmd_o.last = 1'b1;
                done       = 1'b1;
              end else if (stat_i.top_lp) begin
                cmd_o.kind  = KIND_ERROR;
                cmd_o.last  = 1'b1;
                cmd_o.clear = 1'b1;
                done        = 1'b1;
              end else begin
                cmd_o.kind     = KIND_OPERATOR;
                cmd_o.from_top = 1'b1;
                cmd_o.pop      = 1'b1;
              end
            end
          end
          default: begin
            if (stat_i.out_free) begin
              cmd_o.emit  = 1'b1;
              cmd_o.kind  = KIND_ERROR;
              cmd_o.last  = 1'b1;
              cmd_o.clear = 1'b1;
              done        = 1'b1;
            end
          end
        endcase
      end
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
  end

  `ITP_ASSERT_NEXT(a_done_idle, done, state_q == ST_IDLE,
                   "item still running after it completed")

endmodule

// ----- rtl/itp_dp.sv -----
`include "infix_to_postfix_converter_macros.svh"

module itp_dp
  import itp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  in_opcode_i,
  input  logic [3:0]  in_operator_code_i,
  input  logic [15:0] in_token_tag_i,
  input  itp_cmd_t    cmd_i,
  output itp_stat_t   stat_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output itp_kind_e   out_kind_o,
  output logic [3:0]  out_operator_code_o,
  output logic [15:0] out_token_tag_o,
  output logic        out_last_o
);

  logic [2:0]  opcode_q;
  logic [3:0]  opc_q;
  logic [15:0] tag_q;

  logic [SP_W-1:0]   sp_q, sp_d;
  itp_entry_t        top_q, top_d;
  itp_entry_t        mem_q [MEM_DEPTH];
  itp_entry_t        nxt;
  itp_entry_t        new_entry;
  logic [MEM_AW-1:0] wr_addr, rd_addr;
  logic [SP_W-1:0]   sp_m1, sp_m2;
  logic [2:0]        item_prec;
  logic              sp_ge2;
  logic              out_free;

  logic              out_valid_q;
  itp_kind_e         out_kind_q;
  logic [3:0]        out_op_q;
  logic [15:0]       out_tag_q;
  logic              out_last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opcode_q <= in_opcode_i;
      opc_q    <= in_operator_code_i;
      tag_q    <= in_token_tag_i;
    end
  end

  assign sp_m1   = sp_q - SP_W'(1);
  assign sp_m2   = sp_q - SP_W'(2);
  assign wr_addr = sp_m1[MEM_AW-1:0];
  assign rd_addr = sp_m2[MEM_AW-1:0];
  assign nxt     = mem_q[rd_addr];
  assign sp_ge2  = sp_q > SP_W'(1);

  assign item_prec = itp_prec(opc_q);
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    new_entry.lp  = (opcode_q == OPC_LPAREN);
    new_entry.op  = (opcode_q == OPC_LPAREN) ? 4'd0 : opc_q;
    new_entry.tag = tag_q;
  end

  always_comb begin
    stat_o.opcode     = opcode_q;
    stat_o.op_ok      = opc_q <= OP_NOT;
    stat_o.empty      = sp_q == '0;
    stat_o.full       = sp_q == SP_W'(STACK_DEPTH);
    stat_o.top_lp     = top_q.lp;
    stat_o.top_yields = !top_q.lp && (item_prec <= itp_prec(top_q.op));
    stat_o.nxt_lp     = sp_ge2 && nxt.lp;
    stat_o.nxt_yields = sp_ge2 && !nxt.lp && (item_prec <= itp_prec(nxt.op));
    stat_o.out_free   = out_free;
  end

  always_comb begin
    sp_d  = sp_q;
    top_d = top_q;
    priority if (cmd_i.clear) begin
      sp_d = '0;
    end else if (cmd_i.push) begin
      sp_d  = sp_q + SP_W'(1);
      top_d = new_entry;
    end else if (cmd_i.pop) begin
      sp_d = sp_m1;
      if (sp_ge2) top_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (cmd_i.push && (sp_q != '0)) mem_q[wr_addr] <= top_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.kind;
      out_op_q   <= cmd_i.from_top ? top_q.op : 4'd0;
      out_tag_q  <= cmd_i.from_top ? top_q.tag : tag_q;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_kind_o          = out_kind_q;
  assign out_operator_code_o = out_op_q;
  assign out_token_tag_o     = out_tag_q;
  assign out_last_o          = out_last_q;

  `ITP_ASSERT(a_sp_range, sp_q <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
  `ITP_ASSERT(a_emit_free, !cmd_i.emit || out_free, "word overwritten before taken")
  `ITP_ASSERT(a_push_room, !cmd_i.push || (sp_q != SP_W'(STACK_DEPTH)), "push on full stack")
  `ITP_ASSERT(a_pop_data, !cmd_i.pop || (sp_q != '0), "pop on empty stack")

endmodule

// ----- sim/infix_to_postfix_converter_tb.sv -----
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
  import itp_pkg::*;

  localparam int unsigned RANDOM_WORDS = 330;
  localparam int unsigned QUIET_LIMIT  = 5000;

  typedef struct packed {
    logic        is_paren;
    logic [3:0]  op;
    logic [15:0] tag;
  } held_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  op;
    logic [15:0] tag;
    logic        last;
  } postfix_word_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  code;
    logic [15:0] tag;
  } infix_word_t;

  class postfix_tracker;
    held_t         held[STACK_DEPTH];
    int unsigned   depth;
    postfix_word_t expected[$];
    int unsigned   fails;
    int unsigned   words_in;
    int unsigned   words_out;
    int unsigned   ends_seen;
    int unsigned   errs_seen;
    int unsigned   peak;

    function int rank(logic [3:0] code);
      case (code)
        OP_NOT:         return 6;
        OP_MUL, OP_DIV: return 5;
        OP_ADD, OP_SUB: return 4;
        OP_AND:         return 3;
        OP_OR:          return 2;
        default:        return 1;
      endcase
    endfunction

    function void append(itp_kind_e kind, logic [3:0] code, logic [15:0] tag);
      postfix_word_t w;
      w.kind = kind;
      w.op   = code;
      w.tag  = tag;
      w.last = 1'b0;
      expected.push_back(w);
      if (kind == KIND_END) ends_seen++;
      if (kind == KIND_ERROR) errs_seen++;
    endfunction

    function void abort(logic [15:0] tag);
      depth = 0;
      append(KIND_ERROR, '0, tag);
    endfunction

    function void stash(logic is_paren, logic [3:0] code, logic [15:0] tag);
      if (depth >= STACK_DEPTH) begin
        abort(tag);
      end else begin
        held[depth].is_paren = is_paren;
        held[depth].op       = code;
        held[depth].tag      = tag;
        depth++;
        if (depth > peak) peak = depth;
      end
    endfunction

    function void take_infix(logic [2:0] opcode, logic [3:0] code, logic [15:0] tag);
      int unsigned first;
      held_t       top;
      bit          found;
      int          p;
      first = expected.size();
      found = 1'b0;
      words_in++;
      case (opcode)
        OPC_OPERAND: append(KIND_OPERAND, '0, tag);
        OPC_LPAREN:  stash(1'b1, '0, tag);
        OPC_RPAREN, OPC_END: begin
          while (depth > 0) begin
            depth--;
            top = held[depth];
            if (top.is_paren) begin
              found = 1'b1;
              break;
            end
            append(KIND_OPERATOR, top.op, top.tag);
          end
          if (opcode == OPC_RPAREN) begin
            if (!found) abort(tag);
          end else if (found) begin
            abort(tag);
          end else begin
            append(KIND_END, '0, tag);
          end
        end
        OPC_OPERATOR: begin
          if (code > OP_NOT) begin
            abort(tag);
          end else begin
            p = rank(code);
            while (depth > 0) begin
              top = held[depth - 1];
              if (top.is_paren || p > rank(top.op)) break;
              depth--;
              append(KIND_OPERATOR, top.op, top.tag);
            end
            stash(1'b0, code, tag);
          end
        end
        default: abort(tag);
      endcase
      if (expected.size() > first) expected[expected.size() - 1].last = 1'b1;
    endfunction

    function void match_postfix(logic [1:0] kind, logic [3:0] code, logic [15:0] tag,
                                logic last);
      postfix_word_t want;
      words_out++;
      if (expected.size() == 0) begin
        fails++;
        $display("%0t: postfix word with none expected: kind %0d op %0d tag %h last %b",
                 $time, kind, code, tag, last);
        return;
      end
      want = expected.pop_front();
      if (kind !== want.kind) begin
        fails++;
        $display("%0t: out_kind expected %0d, got %0d", $time, want.kind, kind);
      end
      if (code !== want.op) begin
        fails++;
        $display("%0t: out_operator_code expected %0d, got %0d", $time, want.op, code);
      end
      if (tag !== want.tag) begin
        fails++;
        $display("%0t: out_token_tag expected %h, got %h", $time, want.tag, tag);
      end
      if (last !== want.last) begin
        fails++;
        $display("%0t: last expected %b, got %b", $time, want.last, last);
      end
    endfunction

    function int unsigned pending();
      return expected.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  postfix_tracker tracker = new();
  infix_word_t    plan[$];
  int unsigned    sent = 0;
  int unsigned    quiet = 0;
  logic           steady;

  assign steady = (sent >= 120) && (sent < 200);

  infix_to_postfix_converter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 7);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.match_postfix(m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[19:4],
                              m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_infix(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[19:4]);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet);
        $display("infix_to_postfix_converter_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic void put(logic [2:0] opcode, logic [3:0] code, logic [15:0] tag);
    infix_word_t w;
    w.opcode = opcode;
    w.code   = code;
    w.tag    = tag;
    plan.push_back(w);
  endfunction

  function automatic void tok(logic [2:0] opcode);
    put(opcode, 4'($urandom_range(15)), 16'($urandom));
  endfunction

  function automatic void opr(logic [3:0] code);
    put(OPC_OPERATOR, code, 16'($urandom));
  endfunction

  function automatic void gen_expr(int max_nest, int len);
    int nest;
    int n;
    bit need_term;
    int r;
    nest = 0;
    n = 0;
    need_term = 1'b1;
    while (need_term || nest > 0 || n < len) begin
      r = $urandom_range(99);
      if (need_term) begin
        if (n < len && r < 15 && nest < max_nest) begin
          tok(OPC_LPAREN);
          nest++;
        end else if (n < len && r < 25) begin
          opr(OP_NOT);
        end else begin
          tok(OPC_OPERAND);
          need_term = 1'b0;
        end
      end else if (nest > 0 && (n >= len || r < 30)) begin
        tok(OPC_RPAREN);
        nest--;
      end else begin
        opr(4'($urandom_range(OP_DIV)));
        need_term = 1'b1;
      end
      n++;
    end
    tok(OPC_END);
  endfunction

  function automatic void gen_nest(int levels, bit with_ops);
    for (int i = 0; i < levels; i++) begin
      if (with_ops) begin
        tok(OPC_OPERAND);
        opr(4'($urandom_range(OP_DIV)));
      end
      tok(OPC_LPAREN);
    end
    tok(OPC_OPERAND);
    for (int i = 0; i < levels; i++) tok(OPC_RPAREN);
    tok(OPC_END);
  endfunction

  task automatic send_word(infix_word_t w);
    if (!steady) begin
      while ($urandom_range(99) < 7) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, w.tag, w.code};
    s_axis_tuser  <= w.opcode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_plan();
    while (plan.size() != 0) send_word(plan.pop_front());
  endtask

  task automatic hold_off();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned goal;
    int          r;
    int          mark;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // not ( a or b ) and c mul d eq e, with extreme tags
    opr(OP_NOT);
    tok(OPC_LPAREN);
    put(OPC_OPERAND, '1, 16'h0000);
    opr(OP_OR);
    put(OPC_OPERAND, '0, 16'hffff);
    tok(OPC_RPAREN);
    opr(OP_AND);
    tok(OPC_OPERAND);
    opr(OP_MUL);
    tok(OPC_OPERAND);
    opr(OP_EQ);
    tok(OPC_OPERAND);
    tok(OPC_END);
    // unmatched right paren on an empty stack
    tok(OPC_RPAREN);
    // left paren still open at the end marker
    tok(OPC_LPAREN);
    tok(OPC_OPERAND);
    opr(OP_ADD);
    tok(OPC_END);
    // bad operator code and bad opcode
    put(OPC_OPERATOR, '1, 16'hffff);
    put('1, '1, 16'h0000);
    tok(OPC_OPERAND);
    opr(OP_SUB);
    tok(OPC_OPERAND);
    opr(OP_DIV);
    tok(OPC_OPERAND);
    opr(OP_GE);
    tok(OPC_OPERAND);
    tok(OPC_END);
    send_plan();
    hold_off();

    goal = sent + RANDOM_WORDS;
    // fill the stack exactly, then overflow it with operators between parens
    gen_nest(STACK_DEPTH, 1'b0);
    gen_nest(STACK_DEPTH / 2 + 1, 1'b1);
    send_plan();
    hold_off();

    while (sent < goal) begin
      r = $urandom_range(99);
      if (r < 72) begin
        gen_expr(4, $urandom_range(1, 14));
      end else if (r < 84) begin
        mark = plan.size();
        gen_expr(3, $urandom_range(2, 10));
        plan.delete($urandom_range(plan.size() - 1, mark));
      end else if (r < 96) begin
        repeat ($urandom_range(1, 4))
          put(3'($urandom_range(7)), 4'($urandom_range(15)), 16'($urandom));
      end else if (r < 98) begin
        gen_nest($urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 1), 1'b0);
      end else begin
        gen_nest($urandom_range(STACK_DEPTH / 2 - 2, STACK_DEPTH / 2 + 1), 1'b1);
      end
      send_plan();
      if ($urandom_range(99) < 8) hold_off();
    end

    hold_off();
    repeat (40) @(posedge clk_i);

    $display("covered %0d infix and %0d postfix words: %0d expressions closed, %0d errors",
             tracker.words_in, tracker.words_out, tracker.ends_seen, tracker.errs_seen);
    $display("operator stack reached %0d of %0d entries, %0d mismatches",
             tracker.peak, STACK_DEPTH, tracker.fails);
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("infix_to_postfix_converter_tb: done, clean");
    end else begin
      $display("infix_to_postfix_converter_tb: done, errors");
    end
    $finish;
  end

endmodule
